/* rtl/oid_pkg.sv */
// Shared types, constants and fixed-point helpers for the inertialized offset decay unit.
// No dependencies; imported by every other RTL file except oid_delay and oid_div, and by the testbench.
package oid_pkg;

   localparam int OUT_AXES      = 3;
   localparam int PIPE_DEPTH    = 61;
   localparam int SERIES_TERMS  = 12;
   localparam int SCALE_STEPS   = 15;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = 2;

   localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
   localparam logic [30:0] Q30_HALF   = 31'h2000_0000;
   // exp(-1) in Q30 as produced by the truncated series
   localparam logic [30:0] E_INV_Q30  = 31'd395007542;

   localparam logic signed [64:0] SUM_MAX = 65'sh4000_0000_0000_0000;
   localparam logic signed [64:0] SUM_MIN = -65'sh4000_0000_0000_0000;

   localparam logic [2:0] REG_DECAY_RATE     = 3'd0;
   localparam logic [2:0] REG_BLEND_DURATION = 3'd1;
   localparam logic [2:0] REG_OFFSET_X       = 3'd2;
   localparam logic [2:0] REG_OFFSET_Y       = 3'd3;
   localparam logic [2:0] REG_OFFSET_Z       = 3'd4;
   localparam logic [2:0] REG_VELOCITY_X     = 3'd5;
   localparam logic [2:0] REG_VELOCITY_Y     = 3'd6;
   localparam logic [2:0] REG_VELOCITY_Z     = 3'd7;

   localparam logic [2:0] OFFSET_REG   [OUT_AXES] = '{REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z};
   localparam logic [2:0] VELOCITY_REG [OUT_AXES] =
      '{REG_VELOCITY_X, REG_VELOCITY_Y, REG_VELOCITY_Z};

   typedef enum logic [1:0] {
      KIND_HOLD,
      KIND_ZERO,
      KIND_DECAY
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [30:0] t;
   } item_type;

   function automatic logic signed [63:0] sx32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > SUM_MAX) begin
         return SUM_MAX[63:0];
      end else if (s < SUM_MIN) begin
         return SUM_MIN[63:0];
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      return sat_add(a, -b);
   endfunction

   function automatic logic [31:0] pack32(input logic signed [63:0] v);
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         return 32'h7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

/* rtl/oid_delay.sv */
// Enable-gated delay line for pipeline alignment.
// Depends on nothing.
module oid_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];
   logic [WIDTH-1:0] line_in [DEPTH];

   always_comb begin
      line_in[0] = din;
      for (int i = 1; i < DEPTH; i++) begin
         line_in[i] = line_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff <= line_in;
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

/* rtl/oid_qmul.sv */
// Three-stage saturating Q16.16 multiplier on 64-bit operands, built from 32-bit partials.
// Depends on oid_pkg.
module oid_qmul import oid_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic signed [63:0] p
);

   logic        neg_ff, neg2_ff;
   logic [62:0] ma_ff, mb_ff, ma_in, mb_in;
   logic [63:0] p00_ff, p00_in;
   logic [62:0] p01_ff, p10_ff, p01_in, p10_in;
   logic [61:0] p11_ff, p11_in;
   logic [125:0] full;
   logic [109:0] m;
   logic [62:0]  mag;
   logic signed [63:0] p_ff, p_in;

   assign ma_in = a[63] ? 63'(-a) : a[62:0];
   assign mb_in = b[63] ? 63'(-b) : b[62:0];

   assign p00_in = 64'(ma_ff[31:0]) * 64'(mb_ff[31:0]);
   assign p01_in = 63'(ma_ff[31:0]) * 63'(mb_ff[62:32]);
   assign p10_in = 63'(ma_ff[62:32]) * 63'(mb_ff[31:0]);
   assign p11_in = 62'(ma_ff[62:32]) * 62'(mb_ff[62:32]);

   always_comb begin
      full = 126'(p00_ff) + ((126'(p01_ff) + 126'(p10_ff)) << 32) + (126'(p11_ff) << 64)
             + 126'(32768);
      m    = full[125:16];
      mag  = (m > 110'(SUM_MAX[62:0])) ? SUM_MAX[62:0] : m[62:0];
      p_in = neg2_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff  <= a[63] ^ b[63];
         ma_ff   <= ma_in;
         mb_ff   <= mb_in;
         neg2_ff <= neg_ff;
         p00_ff  <= p00_in;
         p01_ff  <= p01_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
         p_ff    <= p_in;
      end
   end

   assign p = p_ff;

endmodule

/* rtl/oid_exp.sv */
// Pipelined exp(-rate*arg) in Q16.16: Horner series on the fraction, then scaling by exp(-1).
// Depends on oid_pkg and oid_delay.
module oid_exp import oid_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] rate,
   input  logic [30:0] arg,
   output logic [16:0] decay
);

   logic [61:0] prod_ff, prod_in;
   logic [46:0] x;
   logic [29:0] y_ff, y_in;
   logic [3:0]  k_ff, k_in;
   logic        big_ff, big_in;
   logic [29:0] hy [SERIES_TERMS+1];
   logic [30:0] hs [SERIES_TERMS+1];
   logic [4:0]  kb_h;
   logic [30:0] se [SCALE_STEPS+1];
   logic [4:0]  sk [SCALE_STEPS+1];
   logic [16:0] decay_ff, decay_in;

   assign prod_in = 62'(rate) * 62'(arg);
   assign x       = 47'((63'(prod_ff) + 63'(32768)) >> 16);
   assign y_in    = {x[15:0], 14'd0};
   assign k_in    = x[19:16];
   assign big_in  = |x[46:20];

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         y_ff    <= y_in;
         k_ff    <= k_in;
         big_ff  <= big_in;
      end
   end

   assign hy[0] = y_ff;
   assign hs[0] = Q30_ONE;

   // one series term per three stages: multiply, reciprocal estimate, correct
   for (genvar j = 0; j < SERIES_TERMS; j++) begin : g_term
      localparam int N = SERIES_TERMS - j;
      localparam logic [32:0] RECIP = 33'((65'd1 << 32) / N);
      logic [60:0] p_ff, p_in;
      logic [30:0] v, v_ff, q0_ff, q0_in, s_ff, s_in, q;
      logic [63:0] vm;
      logic [33:0] qn, r;
      logic [29:0] ya_ff, yb_ff, yc_ff;

      assign p_in  = 61'(hy[j]) * 61'(hs[j]);
      assign v     = 31'((p_ff + 61'(Q30_HALF)) >> 30);
      assign vm    = 64'(v) * 64'(RECIP);
      assign q0_in = vm[62:32];
      assign qn    = 34'(q0_ff) * 34'(N);
      assign r     = 34'(v_ff) - qn;
      assign q     = (r >= 34'(N)) ? q0_ff + 31'd1 : q0_ff;
      assign s_in  = Q30_ONE - q;

      always_ff @(posedge clock) begin
         if (en) begin
            p_ff  <= p_in;
            ya_ff <= hy[j];
            v_ff  <= v;
            q0_ff <= q0_in;
            yb_ff <= ya_ff;
            s_ff  <= s_in;
            yc_ff <= yb_ff;
         end
      end

      assign hy[j+1] = yc_ff;
      assign hs[j+1] = s_ff;
   end

   oid_delay #(.WIDTH(5), .DEPTH(3 * SERIES_TERMS)) u_kdly (
      .clock(clock), .en(en), .din({big_ff, k_ff}), .dout(kb_h)
   );

   assign se[0] = hs[SERIES_TERMS];
   assign sk[0] = kb_h;

   // integer part: multiply by exp(-1) once per whole unit
   for (genvar i = 0; i < SCALE_STEPS; i++) begin : g_scale
      logic [59:0] m;
      logic [30:0] e_ff, e_in;
      logic [4:0]  kb_ff;

      assign m    = 60'(se[i]) * 60'(E_INV_Q30);
      assign e_in = (4'(i) < sk[i][3:0]) ? 31'((m + 60'(Q30_HALF)) >> 30) : se[i];

      always_ff @(posedge clock) begin
         if (en) begin
            e_ff  <= e_in;
            kb_ff <= sk[i];
         end
      end

      assign se[i+1] = e_ff;
      assign sk[i+1] = kb_ff;
   end

   assign decay_in = sk[SCALE_STEPS][4] ? 17'd0
                   : 17'((32'(se[SCALE_STEPS]) + 32'd8192) >> 14);

   always_ff @(posedge clock) begin
      if (en) begin
         decay_ff <= decay_in;
      end
   end

   assign decay = decay_ff;

endmodule

/* rtl/oid_div.sv */
// Pipelined restoring divider: quo = floor(num * 2^16 / den), valid for num < den.
// Depends on nothing. One quotient bit per stage, 16 stages.
module oid_div (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] num,
   input  logic [30:0] den,
   output logic [15:0] quo
);

   logic [30:0] rem [17];
   logic [15:0] qb  [17];

   assign rem[0] = num;
   assign qb[0]  = '0;

   for (genvar i = 0; i < 16; i++) begin : g_bit
      logic [31:0] sh;
      logic        ge;
      logic [30:0] rem_ff, rem_in;
      logic [15:0] q_ff, q_in;

      assign sh     = {rem[i], 1'b0};
      assign ge     = sh >= {1'b0, den};
      assign rem_in = ge ? 31'(sh - {1'b0, den}) : sh[30:0];
      assign q_in   = {qb[i][14:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff <= rem_in;
            q_ff   <= q_in;
         end
      end

      assign rem[i+1] = rem_ff;
      assign qb[i+1]  = q_ff;
   end

   assign quo = qb[16];

endmodule

/* rtl/oid_front.sv */
// Request front end: clamps negative time and classifies the request against the config.
// Depends on oid_pkg.
module oid_front import oid_pkg::*; (
   input  logic [31:0] time_word,
   input  logic [30:0] rate,
   input  logic [30:0] duration,
   output item_type    item
);

   logic [30:0] tc;

   assign tc = time_word[31] ? 31'd0 : time_word[30:0];

   always_comb begin
      item.t = tc;
      if (rate == 31'd0) begin
         item.kind = KIND_HOLD;
      end else if (tc >= duration) begin
         item.kind = KIND_ZERO;
      end else begin
         item.kind = KIND_DECAY;
      end
   end

endmodule

/* rtl/oid_queue.sv */
// Small request queue between the front end and the evaluation pipeline.
// Depends on oid_pkg.
module oid_queue import oid_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   input  logic     pop,
   output logic     pop_valid,
   output item_type pop_item
);

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   logic                     do_push, do_pop;

   assign push_ready = count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_W+1)'(do_push) - (QUEUE_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/inertialized_offset_decay_unit.sv */
// Inertialized offset decay: three-axis critically damped offset with Hermite end correction.
// Throughput: one request per cycle; the pipeline advances whenever the output register frees.
// The depth is set by the exp series pipeline (12 terms, 3 stages each, plus 15 scaling steps).
// Reset: synchronous; clears queue, pipeline valids and output valid, config to its reset values.
module inertialized_offset_decay_unit import oid_pkg::*; #(
   parameter int AXES = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] elapsed_time
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] offset_x, [63:32] offset_y, [95:64] offset_z
   input  logic        csr_wen,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   logic [30:0] decay_rate_ff, decay_rate_in;
   logic [30:0] blend_duration_ff, blend_duration_in;
   logic [31:0] start_offset_ff   [AXES];
   logic [31:0] start_velocity_ff [AXES];

   item_type in_item, head_item;
   logic     head_valid, en;
   logic [PIPE_DEPTH:1] pipe_vld_ff, pipe_vld_in;
   logic [1:0]  kind_bits;
   kind_type    kind_out;
   logic [30:0] t31, t50;
   logic signed [63:0] w64, d64, t50_64, decay64, ed64;
   logic [16:0] decay, end_decay;
   logic [15:0] u, u_d3;
   logic signed [63:0] u2, u3, u2_d3, wvd;
   logic signed [63:0] wv_ff, wv_in, wvel_ff, wvel_in;
   logic [31:0] lane      [OUT_AXES];
   logic [31:0] hold_lane [OUT_AXES];
   logic [31:0] res       [OUT_AXES];
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [95:0] rsp_tdata_ff, rsp_tdata_in;

   // ---------------- configuration
   assign decay_rate_in = (csr_wen && csr_addr == REG_DECAY_RATE) ? csr_wdata[30:0]
                        : decay_rate_ff;
   assign blend_duration_in = (csr_wen && csr_addr == REG_BLEND_DURATION) ? csr_wdata[30:0]
                            : blend_duration_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_rate_ff     <= '0;
         blend_duration_ff <= 31'd65536;
      end else begin
         decay_rate_ff     <= decay_rate_in;
         blend_duration_ff <= blend_duration_in;
      end
   end

   for (genvar a = 0; a < AXES; a++) begin : g_cfg
      logic [31:0] off_in, vel_in;
      assign off_in = (csr_wen && csr_addr == OFFSET_REG[a]) ? csr_wdata : start_offset_ff[a];
      assign vel_in = (csr_wen && csr_addr == VELOCITY_REG[a]) ? csr_wdata
                    : start_velocity_ff[a];
      always_ff @(posedge clock) begin
         if (reset) begin
            start_offset_ff[a]   <= '0;
            start_velocity_ff[a] <= '0;
         end else begin
            start_offset_ff[a]   <= off_in;
            start_velocity_ff[a] <= vel_in;
         end
      end
   end

   // ---------------- front end and queue
   oid_front u_front (
      .time_word(req_tdata), .rate(decay_rate_ff), .duration(blend_duration_ff), .item(in_item)
   );

   oid_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(req_tvalid), .push_ready(req_tready), .push_item(in_item),
      .pop(en), .pop_valid(head_valid), .pop_item(head_item)
   );

   // ---------------- pipeline control
   assign en          = !rsp_tvalid_ff || rsp_tready;
   assign pipe_vld_in = {pipe_vld_ff[PIPE_DEPTH-1:1], head_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff <= '0;
      end else if (en) begin
         pipe_vld_ff <= pipe_vld_in;
      end
   end

   oid_delay #(.WIDTH(2), .DEPTH(PIPE_DEPTH)) u_kind_dly (
      .clock(clock), .en(en), .din(head_item.kind), .dout(kind_bits)
   );
   assign kind_out = kind_type'(kind_bits);

   oid_delay #(.WIDTH(31), .DEPTH(31)) u_t31 (
      .clock(clock), .en(en), .din(head_item.t), .dout(t31)
   );
   oid_delay #(.WIDTH(31), .DEPTH(19)) u_t50 (
      .clock(clock), .en(en), .din(t31), .dout(t50)
   );

   assign w64     = {33'd0, decay_rate_ff};
   assign d64     = {33'd0, blend_duration_ff};
   assign t50_64  = {33'd0, t50};
   assign decay64 = {47'd0, decay};
   assign ed64    = {47'd0, end_decay};

   // ---------------- time-dependent and end-of-blend shared terms
   oid_exp u_exp_t (
      .clock(clock), .en(en), .rate(decay_rate_ff), .arg(head_item.t), .decay(decay)
   );
   oid_exp u_exp_d (
      .clock(clock), .en(en), .rate(decay_rate_ff), .arg(blend_duration_ff), .decay(end_decay)
   );

   oid_div u_div (
      .clock(clock), .en(en), .num(t31), .den(blend_duration_ff), .quo(u)
   );

   oid_qmul u_uu (.clock(clock), .en(en), .a({48'd0, u}), .b({48'd0, u}), .p(u2));
   oid_delay #(.WIDTH(16), .DEPTH(3)) u_u_dly (.clock(clock), .en(en), .din(u), .dout(u_d3));
   oid_qmul u_uuu (.clock(clock), .en(en), .a(u2), .b({48'd0, u_d3}), .p(u3));
   oid_delay #(.WIDTH(64), .DEPTH(3)) u_u2_dly (
      .clock(clock), .en(en), .din(u2), .dout(u2_d3)
   );

   // Hermite weights: 3u^2 - 2u^3 and u^3 - u^2
   assign wv_in   = sat_sub(u2_d3 * 64'sd3, u3 * 64'sd2);
   assign wvel_in = sat_sub(u3, u2_d3);

   always_ff @(posedge clock) begin
      if (en) begin
         wv_ff   <= wv_in;
         wvel_ff <= wvel_in;
      end
   end

   oid_qmul u_wvd (.clock(clock), .en(en), .a(wvel_ff), .b(d64), .p(wvd));

   // ---------------- per-axis lanes
   for (genvar a = 0; a < OUT_AXES; a++) begin : g_axis
      if (a < AXES) begin : g_on
         logic signed [63:0] x0, v0, wx, bt, bd, wb, wbd, raw, raw_end, rev, p1, p2, r1_d;
         logic signed [63:0] b_ff, b_in, a_ff, a_in, ae_ff, ae_in, bv_ff, bv_in;
         logic signed [63:0] r1_ff, r1_in, r2_ff, r2_in;

         assign x0 = sx32(start_offset_ff[a]);
         assign v0 = sx32(start_velocity_ff[a]);

         // b, end offset and end velocity depend on config only and settle early
         oid_qmul u_wx  (.clock(clock), .en(en), .a(w64),  .b(x0),     .p(wx));
         assign b_in = sat_add(v0, wx);
         oid_qmul u_bt  (.clock(clock), .en(en), .a(b_ff), .b(t50_64), .p(bt));
         oid_qmul u_bd  (.clock(clock), .en(en), .a(b_ff), .b(d64),    .p(bd));
         oid_qmul u_wb  (.clock(clock), .en(en), .a(w64),  .b(b_ff),   .p(wb));
         oid_qmul u_wbd (.clock(clock), .en(en), .a(wb),   .b(d64),    .p(wbd));
         assign a_in  = sat_add(x0, bt);
         assign ae_in = sat_add(x0, bd);
         assign bv_in = sat_sub(v0, wbd);

         oid_qmul u_raw (.clock(clock), .en(en), .a(a_ff),  .b(decay64), .p(raw));
         oid_qmul u_re  (.clock(clock), .en(en), .a(ae_ff), .b(ed64),    .p(raw_end));
         oid_qmul u_rev (.clock(clock), .en(en), .a(bv_ff), .b(ed64),    .p(rev));
         oid_qmul u_p1  (.clock(clock), .en(en), .a(wv_ff), .b(raw_end), .p(p1));
         assign r1_in = sat_sub(raw, p1);
         oid_delay #(.WIDTH(64), .DEPTH(2)) u_r1_dly (
            .clock(clock), .en(en), .din(r1_ff), .dout(r1_d)
         );
         oid_qmul u_p2  (.clock(clock), .en(en), .a(wvd),   .b(rev),     .p(p2));
         assign r2_in = sat_sub(r1_d, p2);

         always_ff @(posedge clock) begin
            if (en) begin
               b_ff  <= b_in;
               a_ff  <= a_in;
               ae_ff <= ae_in;
               bv_ff <= bv_in;
               r1_ff <= r1_in;
               r2_ff <= r2_in;
            end
         end

         assign lane[a]      = pack32(r2_ff);
         assign hold_lane[a] = start_offset_ff[a];
      end else begin : g_off
         assign lane[a]      = '0;
         assign hold_lane[a] = '0;
      end
   end

   // ---------------- result select and output register
   always_comb begin
      for (int a = 0; a < OUT_AXES; a++) begin
         case (kind_out)
            KIND_HOLD:  res[a] = hold_lane[a];
            KIND_ZERO:  res[a] = '0;
            KIND_DECAY: res[a] = lane[a];
            default:    res[a] = '0;
         endcase
      end
      rsp_tdata_in  = {res[2], res[1], res[0]};
      rsp_tvalid_in = pipe_vld_ff[PIPE_DEPTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

/* sim/inertialized_offset_decay_unit_tb.sv */
// Testbench for inertialized_offset_decay_unit: directed and random elapsed times over
// several register settings, with results checked against a fixed-point predictor.
// Depends on rtl/oid_pkg.sv and rtl/inertialized_offset_decay_unit.sv.
`timescale 1ns / 1ps

import oid_pkg::*;

class offset_scoreboard;
   logic [30:0] rate;
   logic [30:0] duration;
   longint      x0 [3];
   longint      v0 [3];
   logic [95:0] pending [$];
   int          errors;
   int          checked;

   function void reset_regs();
      rate = 0;
      duration = 31'd65536;
      for (int i = 0; i < 3; i++) begin
         x0[i] = 0;
         v0[i] = 0;
      end
   endfunction

   function void write_reg(logic [2:0] addr, logic [31:0] value);
      case (addr)
         REG_DECAY_RATE:     rate = value[30:0];
         REG_BLEND_DURATION: duration = value[30:0];
         REG_OFFSET_X:       x0[0] = longint'(signed'(value));
         REG_OFFSET_Y:       x0[1] = longint'(signed'(value));
         REG_OFFSET_Z:       x0[2] = longint'(signed'(value));
         REG_VELOCITY_X:     v0[0] = longint'(signed'(value));
         REG_VELOCITY_Y:     v0[1] = longint'(signed'(value));
         REG_VELOCITY_Z:     v0[2] = longint'(signed'(value));
         default: ;
      endcase
   endfunction

   // Q16.16 product, rounded half away from zero, magnitude capped at 2^62
   function longint fx_mul(longint a, longint b);
      logic [127:0] ua;
      logic [127:0] ub;
      logic [127:0] p;
      longint       m;
      ua = 128'(a < 0 ? -a : a);
      ub = 128'(b < 0 ? -b : b);
      p = (ua * ub + 128'(1 << 15)) >> 16;
      if (p > (128'(1) << 62)) begin
         m = longint'(64'd1 << 62);
      end else begin
         m = longint'(p[63:0]);
      end
      return ((a < 0) != (b < 0)) ? -m : m;
   endfunction

   function longint fx_add(longint a, longint b);
      longint lim;
      lim = longint'(64'd1 << 62);
      if (a > 0 && b > lim - a) begin
         return lim;
      end
      if (a < 0 && b < -lim - a) begin
         return -lim;
      end
      return a + b;
   endfunction

   function longint unsigned exp_taylor(longint unsigned y);
      longint unsigned s;
      s = 64'd1 << 30;
      for (int n = 12; n >= 1; n--) begin
         s = (64'd1 << 30) - ((y * s + (64'd1 << 29)) >> 30) / n;
      end
      return s;
   endfunction

   function longint decay_factor(longint unsigned x);
      longint unsigned k;
      longint unsigned e;
      longint unsigned c;
      k = x >> 16;
      if (k >= 16) begin
         return 0;
      end
      e = exp_taylor((x & 64'hFFFF) << 14);
      c = exp_taylor(64'd1 << 30);
      for (int i = 0; i < k; i++) begin
         e = (e * c + (64'd1 << 29)) >> 30;
      end
      return longint'((e + (64'd1 << 13)) >> 14);
   endfunction

   function logic [31:0] clamp32(longint v);
      if (v > 64'sh7FFF_FFFF) begin
         return 32'h7FFF_FFFF;
      end
      if (v < -64'sh8000_0000) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function logic [95:0] offset_at(logic [31:0] t_in);
      longint      t, w, d, dec, dec_end, u, u2, u3, wv, wvel;
      longint      b, raw, raw_end, raw_end_vel, r;
      logic [95:0] res;
      t = longint'(signed'(t_in));
      w = longint'(rate);
      d = longint'(duration);
      res = '0;
      if (t < 0) begin
         t = 0;
      end
      if (rate == 0) begin
         for (int i = 0; i < 3; i++) begin
            res[32*i +: 32] = clamp32(x0[i]);
         end
         return res;
      end
      if (t >= d) begin
         return res;
      end
      dec = decay_factor((longint'(w * t) + (1 << 15)) >> 16);
      dec_end = decay_factor((longint'(w * d) + (1 << 15)) >> 16);
      u = (t << 16) / d;
      u2 = fx_mul(u, u);
      u3 = fx_mul(u2, u);
      wv = fx_add(fx_mul(3 * 65536, u2), -fx_mul(2 * 65536, u3));
      wvel = fx_add(u3, -u2);
      for (int i = 0; i < 3; i++) begin
         b = fx_add(v0[i], fx_mul(w, x0[i]));
         raw = fx_mul(fx_add(x0[i], fx_mul(b, t)), dec);
         raw_end = fx_mul(fx_add(x0[i], fx_mul(b, d)), dec_end);
         raw_end_vel = fx_mul(fx_add(v0[i], -fx_mul(fx_mul(w, b), d)), dec_end);
         r = fx_add(raw, -fx_mul(wv, raw_end));
         r = fx_add(r, -fx_mul(fx_mul(wvel, d), raw_end_vel));
         res[32*i +: 32] = clamp32(r);
      end
      return res;
   endfunction

   function void note_request(logic [31:0] t_in);
      pending.push_back(offset_at(t_in));
   endfunction

   function void check_response(logic [95:0] got);
      logic [95:0] want;
      if (pending.size() == 0) begin
         $error("unexpected response %h", got);
         errors++;
         return;
      end
      want = pending.pop_front();
      checked++;
      for (int i = 0; i < 3; i++) begin
         if (want[32*i +: 32] !== got[32*i +: 32]) begin
            $error("offset_%s expected %h actual %h", i == 0 ? "x" : (i == 1 ? "y" : "z"),
                   want[32*i +: 32], got[32*i +: 32]);
            errors++;
         end
      end
   endfunction
endclass

module inertialized_offset_decay_unit_tb;
   localparam int DRAIN_CYCLES = 80;
   localparam int STALL_LIMIT  = 3000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic        csr_wen = 0;
   logic [2:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   offset_scoreboard sb;
   bit calm = 0;
   int quiet_cycles = 0;
   int sent = 0;
   int settings = 0;

   inertialized_offset_decay_unit dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 32);
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata);
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout waiting for handshake");
         $display("inertialized_offset_decay_unit_tb NOT OK");
         $finish;
      end
   end

   task automatic send_time(logic [31:0] t);
      req_tdata <= t;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.note_request(t);
      sent++;
      if (!calm && $urandom_range(99) < 32) begin
         req_tvalid <= 0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] addr, logic [31:0] value);
      csr_wen <= 1;
      csr_addr <= addr;
      csr_wdata <= value;
      sb.write_reg(addr, value);
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_state(int mode);
      case ($urandom_range(5))
         0: return (mode == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         1: return $urandom;
         default: return 32'(int'($urandom_range(20 * 65536)) - 10 * 65536);
      endcase
   endfunction

   // mode 0/1 push the extremes, mode 2/3 zero the rate or the duration, other modes pick random plausible settings
   task automatic load_setting(int mode);
      logic [31:0] w, d;
      case (mode)
         0: begin w = 32'h7FFF_FFFF; d = 32'h7FFF_FFFF; end
         1: begin w = 32'd1;         d = 32'd1; end
         2: begin w = 32'd0;         d = $urandom_range(8 * 65536, 1); end
         3: begin w = $urandom_range(40 * 65536, 1); d = 32'd0; end
         default: begin
            w = $urandom_range(16 * 65536, 1);
            d = $urandom_range(6 * 65536, 1);
         end
      endcase
      write_reg(REG_DECAY_RATE, w);
      write_reg(REG_BLEND_DURATION, d);
      write_reg(REG_OFFSET_X, pick_state(mode));
      write_reg(REG_OFFSET_Y, pick_state(mode));
      write_reg(REG_OFFSET_Z, pick_state(mode));
      write_reg(REG_VELOCITY_X, pick_state(mode));
      write_reg(REG_VELOCITY_Y, pick_state(mode));
      write_reg(REG_VELOCITY_Z, pick_state(mode));
      csr_wen <= 0;
      settings++;
   endtask

   function automatic logic [31:0] pick_time();
      int unsigned d;
      d = sb.duration;
      case ($urandom_range(9))
         0: return 32'h8000_0000 | $urandom;
         1: return $urandom;
         2: return (d == 0) ? 32'd0 : d + $urandom_range(3 * 65536);
         default: return (d == 0) ? 32'd0 : $urandom_range(d - 1);
      endcase
   endfunction

   initial begin
      sb = new();
      sb.reset_regs();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset values: hold of zero offsets
      send_time(32'd0);
      send_time(32'h7FFF_FFFF);
      send_time(32'h8000_0000);
      drain();

      // hold with nonzero offsets, then decaying blends at the edges of time
      write_reg(REG_OFFSET_X, 32'h7FFF_FFFF);
      write_reg(REG_OFFSET_Y, 32'h8000_0000);
      write_reg(REG_OFFSET_Z, 32'h0001_8000);
      write_reg(REG_VELOCITY_X, 32'h8000_0000);
      write_reg(REG_VELOCITY_Y, 32'h7FFF_FFFF);
      write_reg(REG_VELOCITY_Z, 32'hFFFE_0000);
      csr_wen <= 0;
      send_time(32'd12345);
      send_time(32'hFFFF_FFFF);
      drain();
      write_reg(REG_DECAY_RATE, 32'd3 * 65536);
      write_reg(REG_BLEND_DURATION, 32'd2 * 65536);
      csr_wen <= 0;
      send_time(32'd0);
      send_time(32'd1);
      send_time(32'd65536);
      send_time(32'd131071);
      send_time(32'd131072);
      send_time(32'd131073);
      send_time(32'hFFFF_FFFF);
      send_time(32'h7FFF_FFFF);
      send_time(32'h8000_0000);
      send_time(32'd98304);
      drain();
      load_setting(0);
      send_time(32'd0);
      send_time(32'd1);
      send_time(32'h7FFF_FFFE);
      send_time(32'h7FFF_FFFF);
      drain();
      load_setting(1);
      send_time(32'd0);
      send_time(32'd1);
      drain();

      for (int p = 0; p < 12; p++) begin
         load_setting(p < 4 ? p : 4 + p);
         calm = (p == 6);
         repeat (50) send_time(pick_time());
         calm = 0;
         drain();
      end

      $display("%0d requests over %0d register settings, %0d responses checked",
               sent, settings + 3, sb.checked);
      $display("covered hold, zero past the blend end, clamped negative time and decay");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("inertialized_offset_decay_unit_tb OK");
      end else begin
         $display("inertialized_offset_decay_unit_tb NOT OK");
      end
      $finish;
   end
endmodule

/* inertialized_offset_decay_unit.f */
rtl/oid_pkg.sv
rtl/oid_delay.sv
rtl/oid_qmul.sv
rtl/oid_exp.sv
rtl/oid_div.sv
rtl/oid_front.sv
rtl/oid_queue.sv
rtl/inertialized_offset_decay_unit.sv
sim/inertialized_offset_decay_unit_tb.sv
